// ===== rtl/core/becu_pkg.sv =====
// Shared constants and types for the BLEP edge correction unit.
`timescale 1ns / 1ps

package becu_pkg;

	// Default step table depth
	localparam int TableDepthDef = 4096;

	// Fixed field widths
	localparam int AddrW   = 12;
	localparam int SampW   = 18;
	localparam int PhaseW  = 24;
	localparam int PpsW    = 5;
	localparam int WinW    = PpsW + PhaseW;
	localparam int CorrW   = 24;
	localparam int FracW   = 16;
	localparam int CfgIdxW = 1;
	localparam int CfgW    = 5;

	// Request types
	localparam logic REQ_WRITE   = 1'b0;
	localparam logic REQ_COMPUTE = 1'b1;

	// Configuration register indexes
	localparam logic [CfgIdxW-1:0] REG_PPS    = 1'b0;
	localparam logic [CfgIdxW-1:0] REG_INTERP = 1'b1;

	// Sideband that travels with each request down the pipeline
	typedef struct packed {
		logic                    wr;
		logic [AddrW-1:0]        addr;
		logic signed [SampW-1:0] data;
		logic                    win;
		logic                    right;
		logic                    rising;
		logic signed [SampW-1:0] height;
	} side_t;

endpackage

// ===== rtl/core/becu_if.sv =====
// Request and result channel interfaces of the BLEP edge correction unit.
`timescale 1ns / 1ps

interface becu_req_if;
	logic                                     valid;
	logic                                     ready;
	logic                                     req_type;
	logic [becu_pkg::AddrW-1:0]               table_addr;
	logic signed [becu_pkg::SampW-1:0]        table_data;
	logic [becu_pkg::PhaseW-1:0]              phase;
	logic [becu_pkg::PhaseW-1:0]              phase_step;
	logic signed [becu_pkg::SampW-1:0]        edge_height;
	logic                                     rising;

	modport source (output valid, req_type, table_addr, table_data, phase, phase_step,
		edge_height, rising, input ready);
	modport sink (input valid, req_type, table_addr, table_data, phase, phase_step,
		edge_height, rising, output ready);
endinterface

interface becu_rsp_if;
	logic                                     valid;
	logic                                     ready;
	logic signed [becu_pkg::CorrW-1:0]        correction;
	logic                                     in_window;

	modport source (output valid, correction, in_window, input ready);
	modport sink (input valid, correction, in_window, output ready);
endinterface

// ===== rtl/core/becu_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module becu_ram #(
	parameter int Width = 18,
	parameter int Depth = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/core/becu_divider.sv =====
// Pipelined restoring divider, one quotient bit per stage, with sideband.
`timescale 1ns / 1ps

module becu_divider #(
	parameter int QuoW = 27,
	parameter int RemW = 29
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_vld,
	input  logic [RemW-1:0]       in_rem,
	input  logic [QuoW-1:0]       in_lo,
	input  logic [RemW-1:0]       in_div,
	input  becu_pkg::side_t       in_side,
	output logic                  out_vld,
	output logic [QuoW-1:0]       out_quo,
	output becu_pkg::side_t       out_side
);

	logic                  vld_s  [QuoW+1];
	logic [RemW-1:0]       rem_s  [QuoW+1];
	logic [QuoW-1:0]       lo_s   [QuoW+1];
	logic [RemW-1:0]       div_s  [QuoW+1];
	becu_pkg::side_t       side_s [QuoW+1];

	assign vld_s[0]  = in_vld;
	assign rem_s[0]  = in_rem;
	assign lo_s[0]   = in_lo;
	assign div_s[0]  = in_div;
	assign side_s[0] = in_side;

	for (genvar k = 0; k < QuoW; k++) begin : g_stage
		logic [RemW:0] trial;
		logic          ge;

		// shift in next dividend bit, subtract when it fits
		assign trial = {rem_s[k], lo_s[k][QuoW-1]};
		assign ge    = trial >= {1'b0, div_s[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= ge ? RemW'(trial - {1'b0, div_s[k]}) : trial[RemW-1:0];
				lo_s[k+1]   <= {lo_s[k][QuoW-2:0], ge};
				div_s[k+1]  <= div_s[k];
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_vld  = vld_s[QuoW];
	assign out_quo  = lo_s[QuoW];
	assign out_side = side_s[QuoW];

endmodule

// ===== rtl/core/blep_edge_correction_unit.sv =====
// Top level of the BLEP edge correction unit.
`timescale 1ns / 1ps

// Takes one request per clock while no finished result is held. A table
// write stores one signed Q1.16 step table entry and gives no result; a
// compute request gives one result, the saturated Q7.16 correction and an
// in-window flag. QuoW = clog2(TableDepth/2) + 16 is the number of divider
// stages; the position divide takes one quotient bit per stage. All stages
// advance together and hold while a finished result is not taken. Writes
// reach the table in request order, at the same stage where compute
// requests read it, so a compute request sees every write that came before
// it. Table entries are undefined until written.
module blep_edge_correction_unit #(
	parameter int TableDepth = becu_pkg::TableDepthDef
) (
	input  logic                               clk,
	input  logic                               arst_n,
	becu_req_if.sink                           item,
	becu_rsp_if.source                         result,
	input  logic                               cfg_we,
	input  logic [becu_pkg::CfgIdxW-1:0]       cfg_idx,
	input  logic [becu_pkg::CfgW-1:0]          cfg_data
);

	localparam int Center = TableDepth / 2 - 1;
	localparam int CtrW   = $clog2(Center + 1);
	localparam int QuoW   = CtrW + becu_pkg::FracW;
	localparam int ProdW  = becu_pkg::WinW + CtrW;
	localparam int AW     = $clog2(TableDepth);
	localparam int PosW   = QuoW + 1;
	localparam int IdxW   = CtrW + 1;
	localparam int SW     = becu_pkg::SampW;

	// Config registers
	logic [becu_pkg::PpsW-1:0] pps_q;
	logic                      interp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pps_q    <= becu_pkg::PpsW'(1);
			interp_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				becu_pkg::REG_PPS:    pps_q    <= cfg_data;
				becu_pkg::REG_INTERP: interp_q <= cfg_data[0];
				default:              pps_q    <= pps_q;
			endcase
		end
	end

	// Global advance: everything moves unless a result is held
	logic out_vld_q;
	logic en;
	assign en         = !out_vld_q || result.ready;
	assign item.ready = en;

	// Stage 1: capture request
	logic                         vld_s1;
	becu_pkg::side_t              side_s1;
	logic [becu_pkg::PhaseW-1:0]  phase_s1, step_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (en) vld_s1 <= item.valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1.wr     <= item.req_type == becu_pkg::REQ_WRITE;
			side_s1.addr   <= item.table_addr;
			side_s1.data   <= item.table_data;
			side_s1.win    <= 1'b0;
			side_s1.right  <= 1'b0;
			side_s1.rising <= item.rising;
			side_s1.height <= item.edge_height;
			phase_s1       <= item.phase;
			step_s1        <= item.phase_step;
		end
	end

	// Stage 2: window width
	logic                         vld_s2;
	becu_pkg::side_t              side_s2;
	logic [becu_pkg::PhaseW-1:0]  phase_s2;
	logic [becu_pkg::WinW-1:0]    w_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else if (en) vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2  <= side_s1;
			phase_s2 <= phase_s1;
			w_s2     <= becu_pkg::WinW'(pps_q) * becu_pkg::WinW'(step_s1);
		end
	end

	// Stage 3: window tests, left side wins
	logic [becu_pkg::WinW:0]    wsum;
	logic                       left_c, right_c;
	becu_pkg::side_t            side_c3;
	logic                       vld_s3;
	becu_pkg::side_t            side_s3;
	logic [becu_pkg::WinW-1:0]  num_s3, w_s3;

	assign wsum    = (becu_pkg::WinW+1)'(phase_s2) + (becu_pkg::WinW+1)'(w_s2);
	assign left_c  = wsum > (becu_pkg::WinW+1)'(1 << becu_pkg::PhaseW);
	assign right_c = becu_pkg::WinW'(phase_s2) < w_s2;

	// Window flags ride in the sideband from here on
	always_comb begin
		side_c3       = side_s2;
		side_c3.win   = left_c || right_c;
		side_c3.right = !left_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else if (en) vld_s3 <= vld_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s3       <= side_c3;
			num_s3        <= left_c
				? becu_pkg::WinW'(wsum - (becu_pkg::WinW+1)'(1 << becu_pkg::PhaseW))
				: becu_pkg::WinW'(phase_s2);
			w_s3          <= w_s2;
		end
	end

	// Stage 4: scale numerator by Center, one less than the half-table length
	logic               vld_s4;
	becu_pkg::side_t    side_s4;
	logic [ProdW-1:0]   a_s4;
	logic [becu_pkg::WinW-1:0] w_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s4 <= 1'b0;
		else if (en) vld_s4 <= vld_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s4 <= side_s3;
			a_s4    <= ProdW'(num_s3) * ProdW'(Center);
			w_s4    <= w_s3;
		end
	end

	// Position divide: quotient fits QuoW bits since numerator < divisor
	logic              dv_vld;
	logic [QuoW-1:0]   dv_quo;
	becu_pkg::side_t   dv_side;

	becu_divider #(
		.QuoW (QuoW),
		.RemW (becu_pkg::WinW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s4),
		.in_rem   (a_s4[ProdW-1:CtrW]),
		.in_lo    ({a_s4[CtrW-1:0], becu_pkg::FracW'(0)}),
		.in_div   (w_s4),
		.in_side  (side_s4),
		.out_vld  (dv_vld),
		.out_quo  (dv_quo),
		.out_side (dv_side)
	);

	// Table addressing and writes
	logic [PosW-1:0] pos;
	logic [IdxW-1:0] ip;
	logic [31:0]     ip_nxt;
	logic [AW-1:0]   ra1, ra2, wa;
	logic            wr_en;

	assign pos    = PosW'(dv_quo) + (dv_side.right ? PosW'((Center + 1) << becu_pkg::FracW)
		: PosW'(0));
	assign ip     = pos[PosW-1:becu_pkg::FracW];
	assign ip_nxt = 32'(ip) + 32'd1;
	assign ra1    = (32'(ip) >= 32'(TableDepth)) ? AW'(0) : AW'(ip);
	assign ra2    = (ip_nxt >= 32'(TableDepth)) ? AW'(0) : AW'(ip_nxt);
	assign wa     = AW'(dv_side.addr);
	assign wr_en  = en && dv_vld && dv_side.wr && (32'(dv_side.addr) < 32'(TableDepth));

	logic [SW-1:0] y1_raw, y2_raw;

	becu_ram #(.Width(SW), .Depth(TableDepth)) u_ram_a (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wa),
		.wdata (dv_side.data),
		.re    (en),
		.raddr (ra1),
		.rdata (y1_raw)
	);

	becu_ram #(.Width(SW), .Depth(TableDepth)) u_ram_b (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wa),
		.wdata (dv_side.data),
		.re    (en),
		.raddr (ra2),
		.rdata (y2_raw)
	);

	// Stage 5: table read registered in the RAMs
	logic                         vld_s5;
	becu_pkg::side_t              side_s5;
	logic [becu_pkg::FracW-1:0]   frac_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s5 <= 1'b0;
		else if (en) vld_s5 <= dv_vld;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s5 <= dv_side;
			frac_s5 <= pos[becu_pkg::FracW-1:0];
		end
	end

	// Stage 6: interpolation products
	logic signed [SW-1:0]     y1, y2;
	logic [becu_pkg::FracW:0] omf;
	logic                     vld_s6;
	becu_pkg::side_t          side_s6;
	logic signed [2*SW-1:0]   p1_s6, p2_s6;
	logic signed [SW-1:0]     y1_s6;

	assign y1  = $signed(y1_raw);
	assign y2  = $signed(y2_raw);
	assign omf = (becu_pkg::FracW+1)'(1 << becu_pkg::FracW) - {1'b0, frac_s5};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s6 <= 1'b0;
		else if (en) vld_s6 <= vld_s5;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s6 <= side_s5;
			p1_s6   <= y1 * $signed({1'b0, omf});
			p2_s6   <= y2 * $signed({2'b0, frac_s5});
			y1_s6   <= y1;
		end
	end

	// Stage 7: sum, floor, select, sign by edge direction
	logic signed [2*SW:0]   isum, ishr;
	logic signed [SW-1:0]   blep;
	logic                   vld_s7;
	becu_pkg::side_t        side_s7;
	logic signed [SW:0]     blep_s7;

	assign isum = (2*SW+1)'(p1_s6) + (2*SW+1)'(p2_s6);
	assign ishr = isum >>> becu_pkg::FracW;
	assign blep = interp_q ? ishr[SW-1:0] : y1_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s7 <= 1'b0;
		else if (en) vld_s7 <= vld_s6;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s7 <= side_s6;
			blep_s7 <= side_s6.rising ? (SW+1)'(blep) : -((SW+1)'(blep));
		end
	end

	// Stage 8: scale by edge height
	logic                     vld_s8;
	becu_pkg::side_t          side_s8;
	logic signed [2*SW:0]     prod_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s8 <= 1'b0;
		else if (en) vld_s8 <= vld_s7;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s8 <= side_s7;
			prod_s8 <= side_s7.height * blep_s7;
		end
	end

	// Output register: floor to Q7.16, saturate, zero outside window
	logic signed [2*SW:0]             pshr;
	logic signed [becu_pkg::CorrW-1:0] sat;
	logic signed [becu_pkg::CorrW-1:0] corr_q;
	logic                              win_q;

	assign pshr = prod_s8 >>> becu_pkg::FracW;

	always_comb begin
		priority if (pshr > (2*SW+1)'(signed'(24'sh7FFFFF))) begin
			sat = 24'sh7FFFFF;
		end else if (pshr < (2*SW+1)'(signed'(-24'sh800000))) begin
			sat = -24'sh800000;
		end else begin
			sat = pshr[becu_pkg::CorrW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_vld_q <= 1'b0;
		else if (en) out_vld_q <= vld_s8 && !side_s8.wr;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			corr_q <= side_s8.win ? sat : '0;
			win_q  <= side_s8.win;
		end
	end

	assign result.valid      = out_vld_q;
	assign result.correction = corr_q;
	assign result.in_window  = win_q;

`ifndef ASSERT_OFF
	a_zero_outside: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && !win_q) |-> (corr_q == '0))
		else $error("nonzero correction outside window");

	a_hold_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && !result.ready) |-> !item.ready)
		else $error("request taken while result held");

	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(en && vld_s8 && side_s8.wr) |=> !out_vld_q)
		else $error("table write produced a result");

	a_write_gated: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (dv_vld && dv_side.wr))
		else $error("table write without write request");
`endif

endmodule
